/* rtl/catmull_rom_interpolator_top_assert.svh */
// Assertion macros for the Catmull-Rom interpolator checker.
// Expects clk and rst_n to be visible where a macro is used.
`ifndef CATMULL_ROM_INTERPOLATOR_TOP_ASSERT_SVH
`define CATMULL_ROM_INTERPOLATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define CRI_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define CRI_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cri_pkg.sv */
// Shared constants and types for the Catmull-Rom interpolator.
// Used by the weight generator and the top level; no dependencies.
package cri_pkg;

    // Opcodes
    localparam logic OP_POSITION = 1'b0;
    localparam logic OP_SLOPE    = 1'b1;

    // Q10 parameter limits and basis constants
    localparam logic [10:0] ONE_Q10       = 11'd1024;
    localparam logic [11:0] LIN_BASE_A    = 12'd1024;
    localparam logic [11:0] LIN_BASE_B    = 12'd3072;
    localparam logic signed [31:0] SLOPE_CONST = 32'sh0010_0000;

    // Result window positions in the 64-bit sum
    localparam int POS_LSB   = 30;
    localparam int SLOPE_LSB = 20;
    localparam int RES_W     = 32;

    // Four basis weights for one item
    typedef struct packed {
        logic signed [31:0] wa;
        logic signed [31:0] wb;
        logic signed [31:0] wc;
        logic signed [31:0] wd;
    } weights_t;

endpackage

/* rtl/catmull_rom_interpolator_top.sv */
// Catmull-Rom interpolator top level: five-stage multiply-accumulate pipeline.
// Depends on cri_pkg and cri_weight_gen.
//
// Usage:
//   Input channel in_valid/in_stall carries opcode, four control points and
//   t_q10; a request is taken at a clock edge with in_valid high and in_stall
//   low. Output channel out_valid/out_stall carries result, one per request,
//   in request order.
//   Stages, in order: clamp and tangents with t squared, basis weights,
//   four 32x32 products, pair sums, final sum and window select.
//   Throughput: one request per cycle while in_stall is low; every stage
//   is fully pipelined.
//   Reset (rst_n low, asynchronous) empties every stage; in_stall is low and
//   out_valid low afterwards.
//   When the receiver holds out_stall, result and out_valid hold; the stages
//   behind keep filling empty slots and in_stall rises only once the whole
//   pipe is full.
module catmull_rom_interpolator_top
    import cri_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic signed [31:0] point_before,
    input  logic signed [31:0] point_start,
    input  logic signed [31:0] point_end,
    input  logic signed [31:0] point_after,
    input  logic [10:0]        t_q10,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result
);

    // Stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    // Stage 1 signals
    logic [10:0]        t_next, u_next;
    logic [20:0]        t_sq_next, u_sq_next;
    logic signed [32:0] diff0, diff1;
    logic signed [31:0] m0_next, m1_next;
    logic               s1_op_reg;
    logic [10:0]        s1_t_reg, s1_u_reg;
    logic [20:0]        s1_t_sq_reg, s1_u_sq_reg;
    logic signed [31:0] s1_p1_reg, s1_p2_reg, s1_m0_reg, s1_m1_reg;

    // Stage 2 signals
    weights_t           w_next;
    weights_t           s2_w_reg;
    logic               s2_op_reg;
    logic signed [31:0] s2_p1_reg, s2_p2_reg, s2_m0_reg, s2_m1_reg;

    // Stage 3 signals
    logic signed [63:0] pa_next, pb_next, pc_next, pd_next;
    logic signed [63:0] s3_pa_reg, s3_pb_reg, s3_pc_reg, s3_pd_reg;
    logic               s3_op_reg;

    // Stage 4 signals
    logic [63:0]        s4_sab_reg, s4_scd_reg;
    logic               s4_op_reg;

    // Stage 5 signals
    logic [63:0]        acc_next;
    logic signed [31:0] result_next;
    logic signed [31:0] result_reg;

    // Advance a stage when it is empty or the next one advances
    assign adv5     = !v5_reg || !out_stall;
    assign adv4     = !v4_reg || adv5;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    // Move valid bits along the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: clamp t, square t and 1-t, form half-difference tangents
    always_comb
    begin
        t_next    = (t_q10 > ONE_Q10) ? ONE_Q10 : t_q10;
        u_next    = ONE_Q10 - t_next;
        t_sq_next = t_next * t_next;
        u_sq_next = u_next * u_next;
        diff0     = 33'(point_end) - 33'(point_before);
        diff1     = 33'(point_after) - 33'(point_start);
        m0_next   = diff0[32:1];
        m1_next   = diff1[32:1];
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_op_reg   <= opcode;
            s1_t_reg    <= t_next;
            s1_u_reg    <= u_next;
            s1_t_sq_reg <= t_sq_next;
            s1_u_sq_reg <= u_sq_next;
            s1_p1_reg   <= point_start;
            s1_p2_reg   <= point_end;
            s1_m0_reg   <= m0_next;
            s1_m1_reg   <= m1_next;
        end
    end

    // Stage 2: basis weights
    cri_weight_gen u_weight_gen (
        .opcode  (s1_op_reg),
        .t_sat   (s1_t_reg),
        .u_sat   (s1_u_reg),
        .t_sq    (s1_t_sq_reg),
        .u_sq    (s1_u_sq_reg),
        .weights (w_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            s2_w_reg  <= w_next;
            s2_op_reg <= s1_op_reg;
            s2_p1_reg <= s1_p1_reg;
            s2_p2_reg <= s1_p2_reg;
            s2_m0_reg <= s1_m0_reg;
            s2_m1_reg <= s1_m1_reg;
        end
    end

    // Stage 3: four signed 32x32 products
    assign pa_next = 64'(s2_w_reg.wa) * 64'(s2_p1_reg);
    assign pb_next = 64'(s2_w_reg.wb) * 64'(s2_p2_reg);
    assign pc_next = 64'(s2_w_reg.wc) * 64'(s2_m0_reg);
    assign pd_next = 64'(s2_w_reg.wd) * 64'(s2_m1_reg);

    always_ff @(posedge clk)
    begin
        if (adv3 && v2_reg)
        begin
            s3_pa_reg <= pa_next;
            s3_pb_reg <= pb_next;
            s3_pc_reg <= pc_next;
            s3_pd_reg <= pd_next;
            s3_op_reg <= s2_op_reg;
        end
    end

    // Stage 4: pair sums, wrapping at 64 bits
    always_ff @(posedge clk)
    begin
        if (adv4 && v3_reg)
        begin
            s4_sab_reg <= 64'(s3_pa_reg) + 64'(s3_pb_reg);
            s4_scd_reg <= 64'(s3_pc_reg) + 64'(s3_pd_reg);
            s4_op_reg  <= s3_op_reg;
        end
    end

    // Stage 5: final sum and result window
    always_comb
    begin
        acc_next = s4_sab_reg + s4_scd_reg;
        case (s4_op_reg)
            OP_SLOPE: result_next = signed'(acc_next[SLOPE_LSB +: RES_W]);
            default:  result_next = signed'(acc_next[POS_LSB +: RES_W]);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv5 && v4_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = v5_reg;
    assign result    = result_reg;

endmodule

/* rtl/cri_weight_gen.sv */
// Basis weight generator: Q30 Hermite weights or their Q20 derivatives.
// Depends on cri_pkg for constants and weights_t.
module cri_weight_gen
    import cri_pkg::*;
(
    input  logic        opcode,
    input  logic [10:0] t_sat,
    input  logic [10:0] u_sat,
    input  logic [20:0] t_sq,
    input  logic [20:0] u_sq,
    output weights_t    weights
);

    logic [11:0]        lin_a;
    logic [11:0]        lin_b;
    logic [31:0]        pos_a_u;
    logic [31:0]        pos_b_u;
    logic [31:0]        pos_c_u;
    logic [31:0]        pos_d_u;
    logic signed [31:0] t_s;
    logic signed [31:0] t_sq_s;
    logic signed [31:0] slope_a;

    // Linear factors 2t+1024 and 3072-2t
    assign lin_a = {t_sat, 1'b0} + LIN_BASE_A;
    assign lin_b = LIN_BASE_B - {t_sat, 1'b0};

    // Position weights: one small multiplier per lane, each at most 2^30
    assign pos_a_u = u_sq * lin_a;
    assign pos_b_u = t_sq * lin_b;
    assign pos_c_u = u_sq * t_sat;
    assign pos_d_u = t_sq * u_sat;

    // Slope weights from constant multiples of t and t squared
    assign t_s     = signed'({21'd0, t_sat});
    assign t_sq_s  = signed'({11'd0, t_sq});
    assign slope_a = t_sq_s * 32'sd6 - t_s * 32'sd6144;

    // Select the weight set by opcode
    always_comb
    begin
        case (opcode)
            OP_SLOPE:
            begin
                weights.wa = slope_a;
                weights.wb = -slope_a;
                weights.wc = t_sq_s * 32'sd3 - t_s * 32'sd4096 + SLOPE_CONST;
                weights.wd = t_sq_s * 32'sd3 - t_s * 32'sd2048;
            end
            default:
            begin
                weights.wa = signed'(pos_a_u);
                weights.wb = signed'(pos_b_u);
                weights.wc = signed'(pos_c_u);
                weights.wd = -signed'(pos_d_u);
            end
        endcase
    end

endmodule

/* rtl/cri_checker.sv */
// Port-level checker for the Catmull-Rom interpolator, bound to the top level.
// Depends on catmull_rom_interpolator_top_assert.svh for the assertion macros.
`include "catmull_rom_interpolator_top_assert.svh"

module cri_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               opcode,
    input logic signed [31:0] point_before,
    input logic signed [31:0] point_start,
    input logic signed [31:0] point_end,
    input logic signed [31:0] point_after,
    input logic [10:0]        t_q10,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] result
);

    // A stalled result holds
    `CRI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result), "result changed while stalled")

    // With no result waiting, the pipe has room for a request
    `CRI_ASSERT_SAME(a_room_when_empty, !out_valid, !in_stall, "input stalled with empty output")

    // A request taken while out_stall stays low throughout the pipe reaches the output
    `CRI_ASSERT_NEXT(a_latency, (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall, out_valid, "result missing after pipeline latency")

endmodule

bind catmull_rom_interpolator_top cri_checker u_cri_checker (.*);

/* bench/tb_top.sv */
// Self-checking bench for the Catmull-Rom interpolator: directed and random requests,
// predicted results held in a small scoreboard class, random idling on both channels.
// Depends on cri_pkg and catmull_rom_interpolator_top.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cri_pkg::*;

    localparam int RANDOM_REQUESTS = 1050;
    localparam logic signed [31:0] PT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] PT_MIN = 32'sh8000_0000;

    // Predict results and hold them in request order
    class interp_scoreboard;
        logic signed [31:0] pending_results[$];
        int bad_count;
        int noted;
        int checked;
        int slope_count;
        int clamped_count;

        function new();
            bad_count     = 0;
            noted         = 0;
            checked       = 0;
            slope_count   = 0;
            clamped_count = 0;
        endfunction

        // Hermite weights times points and tangents, summed modulo 2^64
        function automatic logic signed [31:0] interpolate(logic op,
                logic signed [31:0] pb, logic signed [31:0] ps,
                logic signed [31:0] pe, logic signed [31:0] pa, logic [10:0] t_raw);
            longint t;
            longint wa;
            longint wb;
            longint wc;
            longint wd;
            longint tan_in;
            longint tan_out;
            logic [63:0] sum;
            t = (t_raw > ONE_Q10) ? longint'(ONE_Q10) : longint'(t_raw);
            tan_in  = (longint'(pe) - longint'(pb)) >>> 1;
            tan_out = (longint'(pa) - longint'(ps)) >>> 1;
            if (op == OP_POSITION)
            begin
                wa = (t - 1024) * (t - 1024) * (t * 2 + 1024);
                wb = t * t * (3072 - t * 2);
                wc = (1024 - t) * (1024 - t) * t;
                wd = t * (t - 1024) * t;
            end
            else
            begin
                wa = t * 6 * t - t * 6144;
                wb = t * 6144 - t * 6 * t;
                wc = t * 3 * t - t * 4096 + 64'sd1048576;
                wd = t * 3 * t - t * 2048;
            end
            sum = wa * longint'(ps) + wb * longint'(pe) + wc * tan_in + wd * tan_out;
            return (op == OP_POSITION) ? sum[POS_LSB +: RES_W] : sum[SLOPE_LSB +: RES_W];
        endfunction

        function void note_request(logic op, logic signed [31:0] pb,
                logic signed [31:0] ps, logic signed [31:0] pe,
                logic signed [31:0] pa, logic [10:0] t_raw);
            pending_results.push_back(interpolate(op, pb, ps, pe, pa, t_raw));
            noted++;
            if (op == OP_SLOPE)
                slope_count++;
            if (t_raw > ONE_Q10)
                clamped_count++;
        endfunction

        task report_mismatch(string msg);
            bad_count++;
            $display("[%0t] mismatch %0d: %s", $realtime, bad_count, msg);
        endtask

        task check_result(logic signed [31:0] got);
            logic signed [31:0] want;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with no request waiting", got));
            end
            else
            begin
                want = pending_results.pop_front();
                checked++;
                if (got !== want)
                    report_mismatch($sformatf("result %0d: got %0d, predicted %0d",
                                              checked, got, want));
            end
        endtask

        function int pending_count();
            return pending_results.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               opcode;
    logic signed [31:0] point_before;
    logic signed [31:0] point_start;
    logic signed [31:0] point_end;
    logic signed [31:0] point_after;
    logic [10:0]        t_q10;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] result;

    interp_scoreboard sb = new();
    bit long_hold_done = 1'b0;

    catmull_rom_interpolator_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .point_before (point_before),
        .point_start  (point_start),
        .point_end    (point_end),
        .point_after  (point_after),
        .t_q10        (t_q10),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result       (result)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Offer one request and hold it until the block takes it
    task drive_request(logic op, logic signed [31:0] pb, logic signed [31:0] ps,
                       logic signed [31:0] pe, logic signed [31:0] pa, logic [10:0] t_raw);
        bit took;
        in_valid     <= 1'b1;
        opcode       <= op;
        point_before <= pb;
        point_start  <= ps;
        point_end    <= pe;
        point_after  <= pa;
        t_q10        <= t_raw;
        do
        begin
            @(negedge clk);
            took = !in_stall;
            if (took)
                sb.note_request(opcode, point_before, point_start, point_end,
                                point_after, t_q10);
            @(posedge clk);
        end
        while (!took);
    endtask

    function automatic logic signed [31:0] rand_point();
        case ($urandom_range(0, 5))
            0: return PT_MAX;
            1: return PT_MIN;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [10:0] rand_t();
        case ($urandom_range(0, 9))
            7: return $urandom_range(0, 1) ? ONE_Q10 : 11'd0;
            8, 9: return 11'($urandom_range(1025, 2047));
            default: return 11'($urandom_range(0, 1024));
        endcase
    endfunction

    // Edge values, both operations, clamping of t, wide tangents and wrapping sums
    task apply_directed();
        drive_request(OP_POSITION, 0, 0, 0, 0, 11'd0);
        drive_request(OP_SLOPE, 0, 0, 0, 0, ONE_Q10);
        drive_request(OP_POSITION, 100, 200, 300, 400, 11'd0);
        drive_request(OP_POSITION, 100, 200, 300, 400, ONE_Q10);
        drive_request(OP_POSITION, 100, 200, 300, 400, 11'd512);
        drive_request(OP_SLOPE, 100, 200, 300, 400, 11'd0);
        drive_request(OP_SLOPE, 100, 200, 300, 400, 11'd512);
        drive_request(OP_SLOPE, 100, 200, 300, 400, ONE_Q10);
        drive_request(OP_POSITION, -7, 13, -29, 41, 11'd1025);
        drive_request(OP_SLOPE, -7, 13, -29, 41, 11'd2047);
        drive_request(OP_POSITION, PT_MIN, PT_MIN, PT_MAX, PT_MAX, 11'd512);
        drive_request(OP_SLOPE, PT_MIN, PT_MIN, PT_MAX, PT_MAX, 11'd300);
        drive_request(OP_POSITION, PT_MAX, PT_MAX, PT_MIN, PT_MIN, 11'd700);
        drive_request(OP_SLOPE, PT_MAX, PT_MAX, PT_MIN, PT_MIN, ONE_Q10);
        drive_request(OP_POSITION, PT_MAX, PT_MAX, PT_MAX, PT_MAX, 11'd1);
        drive_request(OP_SLOPE, PT_MAX, PT_MAX, PT_MAX, PT_MAX, 11'd1);
        drive_request(OP_POSITION, PT_MIN, PT_MIN, PT_MIN, PT_MIN, 11'd1023);
        drive_request(OP_SLOPE, PT_MIN, PT_MIN, PT_MIN, PT_MIN, 11'd2047);
        drive_request(OP_POSITION, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                      32'shAAAA_AAAA, 11'h555);
        drive_request(OP_SLOPE, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                      32'sh5555_5555, 11'h2AA);
        drive_request(OP_POSITION, PT_MIN, PT_MAX, PT_MIN, PT_MAX, 11'd256);
        drive_request(OP_SLOPE, PT_MAX, PT_MIN, PT_MAX, PT_MIN, 11'd768);
    endtask

    // Send random requests in bursts, with idle gaps between some of them
    task apply_random();
        int sent;
        int burst;
        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && sent < RANDOM_REQUESTS; i++)
            begin
                drive_request($urandom_range(0, 1) ? OP_SLOPE : OP_POSITION,
                              rand_point(), rand_point(), rand_point(), rand_point(),
                              rand_t());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    // Reset, stimulus and end of run
    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        opcode       <= OP_POSITION;
        point_before <= '0;
        point_start  <= '0;
        point_end    <= '0;
        point_after  <= '0;
        t_q10        <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apply_directed();
        apply_random();
        in_valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Checked %0d results from %0d requests: %0d slope, %0d with t clamped.",
                 sb.checked, sb.noted, sb.slope_count, sb.clamped_count);
        $display("Receiver held off for a long stretch: %0d; mismatches: %0d.",
                 long_hold_done, sb.bad_count);
        if (sb.bad_count == 0)
            $display("catmull_rom_interpolator_top test passed");
        else
            $display("catmull_rom_interpolator_top test failed");
        $finish;
    end

    // Stall the output on a pattern of its own, with one long hold-off to fill the pipe
    initial
    begin
        int mode;
        forever
        begin
            if (!long_hold_done && sb.checked >= 400)
            begin
                out_stall <= 1'b1;
                repeat (120) @(posedge clk);
                long_hold_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(5, 40))
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= $urandom_range(0, 1);
                    default: out_stall <= ($urandom_range(0, 9) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Check every result taken from the output
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(result);
    end

    // Abandon a run that hangs
    initial
    begin
        #2_000_000;
        $display("catmull_rom_interpolator_top test failed");
        $finish;
    end

endmodule
